// File: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and codes shared by the barrier path allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int SIZE_W      = 12;
	localparam int SLOT_W      = 8;
	localparam int CREDIT_W    = 16;
	localparam int TASK_W      = 16;
	localparam int WAVE_W      = 8;
	localparam int RESERVE_W   = 7;
	localparam int REG_INDEX_W = 3;
	localparam int REG_DATA_W  = 16;
	localparam int UTIL_W      = 15;

	localparam logic [RESERVE_W-1:0] PERCENT_FULL = 7'd100;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] HINT_NONE   = 2'd0;
	localparam logic [1:0] HINT_SLOT   = 2'd1;
	localparam logic [1:0] HINT_CREDIT = 2'd2;
	localparam logic [1:0] HINT_HOST   = 2'd3;

	localparam logic [REG_INDEX_W-1:0] REG_SLOT_TOTAL      = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_CREDIT_TOTAL    = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_LARGE_THRESHOLD = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_SMALL_THRESHOLD = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_RESERVE_PERCENT = 3'd4;

	typedef enum logic [1:0] {
		PATH_SLOT   = 2'd0,
		PATH_CREDIT = 2'd1,
		PATH_HOST   = 2'd2
	} path_t;

	typedef struct packed {
		logic [SLOT_W-1:0]    slot_total;
		logic [CREDIT_W-1:0]  credit_total;
		logic [SIZE_W-1:0]    large_threshold;
		logic [SIZE_W-1:0]    small_threshold;
		logic [RESERVE_W-1:0] reserve_percent;
	} cfg_t;

	typedef struct packed {
		logic              operation;
		logic [SIZE_W-1:0] member_count;
		logic [1:0]        route_hint;
		logic [1:0]        held_path;
		logic [TASK_W-1:0] task_number;
		logic [WAVE_W-1:0] wave_number;
	} req_t;

	typedef struct packed {
		logic [TASK_W-1:0]   granted_task;
		logic [1:0]          granted_path;
		logic [WAVE_W-1:0]   granted_wave;
		logic [SLOT_W-1:0]   slots_in_use;
		logic [CREDIT_W-1:0] credits_in_use;
	} grant_t;

	// classified item held between front and back
	typedef struct packed {
		logic              release_op;
		logic [1:0]        held_path;
		logic [SIZE_W-1:0] member_count;
		path_t             first_path;
		logic              mid_class;
		logic              half_big;
		logic [TASK_W-1:0] task_number;
		logic [WAVE_W-1:0] wave_number;
	} item_t;

endpackage

// File: sv/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if
// Valid/ready channels for request items and grant items.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic          valid;
	logic          ready;
	bpa_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface bpa_grant_if;
	logic            valid;
	logic            ready;
	bpa_pkg::grant_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// File: sv/bpa_front.sv
// ----------------------------------------------------------------------------
// bpa_front
// Accepts items and sorts requests by hint and group size class.
// ----------------------------------------------------------------------------
module bpa_front (
	bpa_req_if.sink        req,
	input  bpa_pkg::cfg_t  cfg,
	input  logic           queue_full,
	output logic           push,
	output bpa_pkg::item_t push_item
);
	import bpa_pkg::*;

	logic is_large;
	logic is_small;

	assign req.ready = !queue_full;
	assign push      = req.valid && !queue_full;

	assign is_large = req.data.member_count >= cfg.large_threshold;
	assign is_small = req.data.member_count < cfg.small_threshold;

	always_comb begin
		push_item.release_op   = (req.data.operation == OP_RELEASE);
		push_item.held_path    = req.data.held_path;
		push_item.member_count = req.data.member_count;
		push_item.task_number  = req.data.task_number;
		push_item.wave_number  = req.data.wave_number;
		push_item.half_big     = {req.data.member_count, 1'b0} > {1'b0, cfg.large_threshold};
		push_item.mid_class    = 1'b0;
		push_item.first_path   = PATH_HOST;
		case (req.data.route_hint)
			HINT_SLOT:   push_item.first_path = PATH_SLOT;
			HINT_CREDIT: push_item.first_path = PATH_CREDIT;
			HINT_HOST:   push_item.first_path = PATH_HOST;
			default: begin
				if (is_large) begin
					push_item.first_path = PATH_SLOT;
				end else if (is_small) begin
					push_item.first_path = PATH_CREDIT;
				end else begin
					push_item.mid_class  = 1'b1;
					push_item.first_path = PATH_CREDIT;
				end
			end
		endcase
	end

endmodule

// File: sv/bpa_queue.sv
// ----------------------------------------------------------------------------
// bpa_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
module bpa_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpa_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output bpa_pkg::item_t head
);
	import bpa_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: sv/bpa_back.sv
// ----------------------------------------------------------------------------
// bpa_back
// Picks the final path against current use, updates the counters and
// holds the grant item in an output register.
// ----------------------------------------------------------------------------
module bpa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bpa_pkg::cfg_t  cfg,
	input  logic           item_valid,
	input  bpa_pkg::item_t item,
	output logic           pop,
	bpa_grant_if.source    grant
);
	import bpa_pkg::*;

	logic [SLOT_W-1:0]    slot_used_q;
	logic [CREDIT_W-1:0]  credit_used_q;
	logic                 out_valid_q;
	grant_t               out_data_q;

	logic                 out_free;
	logic                 slot_free;
	logic [CREDIT_W:0]    credit_sum;
	logic                 credits_fit;
	logic [RESERVE_W-1:0] keep;
	logic [UTIL_W-1:0]    util_lhs;
	logic [UTIL_W-1:0]    util_rhs;
	logic                 below_reserve;
	path_t                chosen;
	path_t                final_path;
	logic [SLOT_W-1:0]    slot_next;
	logic [CREDIT_W-1:0]  credit_next;

	assign out_free    = !out_valid_q || grant.ready;
	assign pop         = item_valid && (item.release_op || out_free);
	assign grant.valid = out_valid_q;
	assign grant.data  = out_data_q;

	assign slot_free   = slot_used_q < cfg.slot_total;
	assign credit_sum  = {1'b0, credit_used_q} + (CREDIT_W + 1)'(item.member_count);
	assign credits_fit = credit_sum <= {1'b0, cfg.credit_total};

	assign keep     = (cfg.reserve_percent > PERCENT_FULL) ? PERCENT_FULL : cfg.reserve_percent;
	assign util_lhs = UTIL_W'(slot_used_q) * UTIL_W'(PERCENT_FULL);
	assign util_rhs = UTIL_W'(cfg.slot_total) * UTIL_W'(PERCENT_FULL - keep);
	assign below_reserve = util_lhs < util_rhs;

	always_comb begin
		chosen = item.first_path;
		if (item.mid_class) begin
			if (below_reserve && slot_free && item.half_big) begin
				chosen = PATH_SLOT;
			end else if (credits_fit) begin
				chosen = PATH_CREDIT;
			end else if (slot_free) begin
				chosen = PATH_SLOT;
			end else begin
				chosen = PATH_HOST;
			end
		end
		final_path = chosen;
		if (final_path == PATH_SLOT && !slot_free) begin
			final_path = PATH_CREDIT;
		end
		if (final_path == PATH_CREDIT && !credits_fit) begin
			final_path = PATH_HOST;
		end
	end

	always_comb begin
		slot_next   = slot_used_q;
		credit_next = credit_used_q;
		if (item.release_op) begin
			case (item.held_path)
				2'(PATH_SLOT): begin
					if (slot_used_q != '0) begin
						slot_next = slot_used_q - 1'b1;
					end
				end
				2'(PATH_CREDIT): begin
					if (credit_used_q >= CREDIT_W'(item.member_count)) begin
						credit_next = credit_used_q - CREDIT_W'(item.member_count);
					end
				end
				default: ;
			endcase
		end else begin
			case (final_path)
				PATH_SLOT:   slot_next   = slot_used_q + 1'b1;
				PATH_CREDIT: credit_next = credit_sum[CREDIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q   <= '0;
			credit_used_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				slot_used_q   <= slot_next;
				credit_used_q <= credit_next;
			end
			if (pop && !item.release_op) begin
				out_valid_q <= 1'b1;
			end else if (grant.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !item.release_op) begin
			out_data_q.granted_task   <= item.task_number;
			out_data_q.granted_path   <= final_path;
			out_data_q.granted_wave   <= item.wave_number;
			out_data_q.slots_in_use   <= slot_next;
			out_data_q.credits_in_use <= credit_next;
		end
	end

endmodule

// File: sv/barrier_path_allocator.sv
// ----------------------------------------------------------------------------
// barrier_path_allocator
// Chooses a barrier synchronization path (slot, credits or host) for each
// request item and frees paths on release items.
//
//   channel   dir   handshake       payload
//   req       in    valid/ready     operation, member_count, route_hint,
//                                   held_path, task_number, wave_number
//   grant     out   valid/ready     granted_task, granted_path, granted_wave,
//                                   slots_in_use, credits_in_use
//   cfg       in    cfg_write       cfg_index, cfg_data
//
// one item per cycle sustained while grant items are taken; a request's grant
// passes through the queue entry written at acceptance, then the output register
// the allocation stage reads and updates both use counters in the same cycle
// releases give no grant item and never wait on the grant channel
// reset clears the counters, the queue and the output valid; registers
// return to their default values
// ----------------------------------------------------------------------------
module barrier_path_allocator #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bpa_pkg::REG_INDEX_W-1:0]   cfg_index,
	input  logic [bpa_pkg::REG_DATA_W-1:0]    cfg_data,
	bpa_req_if.sink                           req,
	bpa_grant_if.source                       grant
);
	import bpa_pkg::*;

	cfg_t  cfg_q;
	logic  queue_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  not_empty;
	item_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_total      <= 8'd16;
			cfg_q.credit_total    <= 16'd256;
			cfg_q.large_threshold <= 12'd64;
			cfg_q.small_threshold <= 12'd16;
			cfg_q.reserve_percent <= 7'd25;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SLOT_TOTAL:      cfg_q.slot_total      <= cfg_data[SLOT_W-1:0];
				REG_CREDIT_TOTAL:    cfg_q.credit_total    <= cfg_data[CREDIT_W-1:0];
				REG_LARGE_THRESHOLD: cfg_q.large_threshold <= cfg_data[SIZE_W-1:0];
				REG_SMALL_THRESHOLD: cfg_q.small_threshold <= cfg_data[SIZE_W-1:0];
				REG_RESERVE_PERCENT: cfg_q.reserve_percent <= cfg_data[RESERVE_W-1:0];
				default: ;
			endcase
		end
	end

	bpa_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	bpa_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	bpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (not_empty),
		.item       (head),
		.pop        (pop),
		.grant      (grant)
	);

endmodule

// File: sv/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the grant channel of the barrier path allocator.
// ----------------------------------------------------------------------------
module bpa_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            grant_valid,
	input  logic            grant_ready,
	input  bpa_pkg::grant_t grant_data
);
	import bpa_pkg::*;

	// a waiting grant item holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		grant_valid && !grant_ready |=> grant_valid && $stable(grant_data))
		else $error("grant item changed while stalled");

	// no grant during reset
	assert property (@(posedge clk) !arst_n |-> !grant_valid)
		else $error("grant valid during reset");

	// a granted path is one of the three paths
	assert property (@(posedge clk) disable iff (!arst_n)
		grant_valid |-> grant_data.granted_path == PATH_SLOT
			|| grant_data.granted_path == PATH_CREDIT
			|| grant_data.granted_path == PATH_HOST)
		else $error("grant path code out of range");

	// a slot grant leaves at least that slot in use
	assert property (@(posedge clk) disable iff (!arst_n)
		grant_valid && grant_data.granted_path == PATH_SLOT
			|-> grant_data.slots_in_use != '0)
		else $error("slot grant with no slot in use");

endmodule

bind barrier_path_allocator bpa_checker u_bpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.grant_valid (grant.valid),
	.grant_ready (grant.ready),
	.grant_data  (grant.data)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks barrier_path_allocator: a short directed table under the default
// registers, then random request/release traffic over several register
// settings. Each grant item is compared field by field with an in-order
// prediction of path choice, demotion and counter updates.
// ----------------------------------------------------------------------------
module testbench;
	import bpa_pkg::*;

	typedef struct packed {
		path_t             path;
		logic [SIZE_W-1:0] size;
	} holding_t;

	typedef struct packed {
		req_t   item;
		logic   typed;
		grant_t grant;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [REG_INDEX_W-1:0] cfg_index;
	logic [REG_DATA_W-1:0] cfg_data;

	bpa_req_if req_ch ();
	bpa_grant_if grant_ch ();

	barrier_path_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.grant     (grant_ch)
	);

	cfg_t alloc_cfg;
	logic [SLOT_W-1:0] slots_held;
	logic [CREDIT_W-1:0] credits_held;
	grant_t pending_grants[$];
	holding_t held_grants[$];
	int mismatches = 0;
	logic calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic allocate_path(input req_t it, output grant_t g);
		int unsigned size, slots, credits, keep;
		logic slot_free, credit_fit;
		path_t path;
		size = 32'(it.member_count);
		slots = 32'(slots_held);
		credits = 32'(credits_held);
		slot_free = slots < 32'(alloc_cfg.slot_total);
		credit_fit = credits + size <= 32'(alloc_cfg.credit_total);
		g = '0;
		if (it.operation == OP_RELEASE) begin
			if (it.held_path == PATH_SLOT) begin
				if (slots > 0) slots_held = slots_held - 1'b1;
			end else if (it.held_path == PATH_CREDIT) begin
				if (credits >= size) credits_held = credits_held - CREDIT_W'(it.member_count);
			end
			return 1'b0;
		end
		keep = 32'((alloc_cfg.reserve_percent > PERCENT_FULL) ? PERCENT_FULL
			: alloc_cfg.reserve_percent);
		if (it.route_hint == HINT_SLOT) path = PATH_SLOT;
		else if (it.route_hint == HINT_CREDIT) path = PATH_CREDIT;
		else if (it.route_hint == HINT_HOST) path = PATH_HOST;
		else if (size >= 32'(alloc_cfg.large_threshold)) path = PATH_SLOT;
		else if (size < 32'(alloc_cfg.small_threshold)) path = PATH_CREDIT;
		else if (slots * 32'(PERCENT_FULL)
				< 32'(alloc_cfg.slot_total) * (32'(PERCENT_FULL) - keep)
				&& slot_free && (size << 1) > 32'(alloc_cfg.large_threshold))
			path = PATH_SLOT;
		else if (credit_fit) path = PATH_CREDIT;
		else if (slot_free) path = PATH_SLOT;
		else path = PATH_HOST;
		// unsafe choices fall through to the next path
		if (path == PATH_SLOT && !slot_free) path = PATH_CREDIT;
		if (path == PATH_CREDIT && !credit_fit) path = PATH_HOST;
		if (path == PATH_SLOT) slots_held = slots_held + 1'b1;
		else if (path == PATH_CREDIT) credits_held = credits_held + CREDIT_W'(it.member_count);
		g.granted_task = it.task_number;
		g.granted_path = path;
		g.granted_wave = it.wave_number;
		g.slots_in_use = slots_held;
		g.credits_in_use = credits_held;
		return 1'b1;
	endfunction

	function automatic row_t make_row(logic op, logic [SIZE_W-1:0] size, logic [1:0] hint,
			logic [1:0] held, logic [TASK_W-1:0] tsk, logic [WAVE_W-1:0] wave,
			logic typed, path_t path, logic [SLOT_W-1:0] slots,
			logic [CREDIT_W-1:0] credits);
		row_t r;
		r.item.operation = op;
		r.item.member_count = size;
		r.item.route_hint = hint;
		r.item.held_path = held;
		r.item.task_number = tsk;
		r.item.wave_number = wave;
		r.typed = typed;
		r.grant.granted_task = tsk;
		r.grant.granted_path = path;
		r.grant.granted_wave = wave;
		r.grant.slots_in_use = slots;
		r.grant.credits_in_use = credits;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic push_request(req_t it, logic typed, grant_t typed_grant);
		grant_t g;
		while (!calm && $urandom_range(0, 99) < 35) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (allocate_path(it, g)) begin
			if (g.granted_path != PATH_HOST) held_grants.push_back({path_t'(g.granted_path),
				it.member_count});
			pending_grants.push_back(typed ? typed_grant : g);
		end
	endtask

	// releases give no item back, so allow the pipeline to empty too
	task automatic settle_block();
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_registers(cfg_t c);
		logic [REG_INDEX_W-1:0] order [5];
		logic [REG_DATA_W-1:0] value [5];
		order = '{REG_SLOT_TOTAL, REG_CREDIT_TOTAL, REG_LARGE_THRESHOLD,
			REG_SMALL_THRESHOLD, REG_RESERVE_PERCENT};
		value = '{REG_DATA_W'(c.slot_total), REG_DATA_W'(c.credit_total),
			REG_DATA_W'(c.large_threshold), REG_DATA_W'(c.small_threshold),
			REG_DATA_W'(c.reserve_percent)};
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= value[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		alloc_cfg = c;
	endtask

	always @(posedge clk) begin
		grant_ch.ready <= calm || $urandom_range(0, 99) >= 35;
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && grant_ch.valid && grant_ch.ready) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				$display("%0t grant expected none actual %h", $time, grant_ch.data);
			end else begin
				want = pending_grants.pop_front();
				check_field("granted_task", want.granted_task, grant_ch.data.granted_task);
				check_field("granted_path", 16'(want.granted_path),
					16'(grant_ch.data.granted_path));
				check_field("granted_wave", 16'(want.granted_wave),
					16'(grant_ch.data.granted_wave));
				check_field("slots_in_use", 16'(want.slots_in_use),
					16'(grant_ch.data.slots_in_use));
				check_field("credits_in_use", want.credits_in_use,
					grant_ch.data.credits_in_use);
			end
		end
	end

	initial begin
		row_t plan[$];
		cfg_t settings [6];
		req_t it;
		holding_t h;
		int v, idx;

		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_SLOT_TOTAL;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		alloc_cfg = '{slot_total: 8'd16, credit_total: 16'd256, large_threshold: 12'd64,
			small_threshold: 12'd16, reserve_percent: 7'd25};
		slots_held = '0;
		credits_held = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: slots 16, credits 256, large 64, small 16, reserve 25
		plan.push_back(make_row(OP_REQUEST, 12'hFFF, HINT_NONE, 2'd0, 16'hFFFF, 8'hFF,
			1'b1, PATH_SLOT, 8'd1, 16'd1 - 16'd1));
		plan.push_back(make_row(OP_REQUEST, 12'd1, HINT_NONE, 2'd3, 16'h0000, 8'h00,
			1'b1, PATH_CREDIT, 8'd1, 16'd1));
		// zero size on credits
		plan.push_back(make_row(OP_REQUEST, 12'd0, HINT_CREDIT, 2'd0, 16'h1234, 8'h5A,
			1'b1, PATH_CREDIT, 8'd1, 16'd1));
		plan.push_back(make_row(OP_REQUEST, 12'd40, HINT_NONE, 2'd1, 16'h0101, 8'h11,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd20, HINT_NONE, 2'd2, 16'h0202, 8'h22,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd32, HINT_NONE, 2'd0, 16'h0303, 8'h33,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd64, HINT_NONE, 2'd0, 16'h0404, 8'h44,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd63, HINT_NONE, 2'd0, 16'h0505, 8'h55,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd100, HINT_HOST, 2'd0, 16'hA5A5, 8'h5A,
			1'b1, PATH_HOST, 8'd4, 16'd53));
		plan.push_back(make_row(OP_REQUEST, 12'd5, HINT_SLOT, 2'd0, 16'h0606, 8'h66,
			1'b0, PATH_HOST, '0, '0));
		// forced credits that do not fit end on host
		plan.push_back(make_row(OP_REQUEST, 12'd300, HINT_CREDIT, 2'd0, 16'h5A5A, 8'hA5,
			1'b1, PATH_HOST, 8'd5, 16'd53));
		plan.push_back(make_row(OP_REQUEST, 12'd203, HINT_CREDIT, 2'd0, 16'h0707, 8'h77,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd1, HINT_NONE, 2'd0, 16'h0808, 8'h88,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd20, HINT_NONE, 2'd0, 16'h0909, 8'h99,
			1'b0, PATH_HOST, '0, '0));
		// releases: more credits than held, host, unused code, then the real ones
		plan.push_back(make_row(OP_RELEASE, 12'd300, HINT_SLOT, PATH_CREDIT, 16'hFFFF, 8'hFF,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_RELEASE, 12'd5, HINT_HOST, PATH_HOST, 16'h0000, 8'h00,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_RELEASE, 12'hFFF, HINT_NONE, 2'd3, 16'h0000, 8'h00,
			1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_RELEASE, 12'd256, HINT_NONE, PATH_CREDIT, 16'h0000, 8'h00,
			1'b0, PATH_HOST, '0, '0));
		repeat (7) plan.push_back(make_row(OP_RELEASE, 12'd0, HINT_NONE, PATH_SLOT,
			16'h0000, 8'h00, 1'b0, PATH_HOST, '0, '0));
		plan.push_back(make_row(OP_REQUEST, 12'd16, HINT_NONE, 2'd0, 16'h0A0A, 8'hAA,
			1'b0, PATH_HOST, '0, '0));

		foreach (plan[i]) push_request(plan[i].item, plan[i].typed, plan[i].grant);
		req_ch.valid <= 1'b0;
		held_grants.delete();

		settings[0] = '{slot_total: 8'd1, credit_total: 16'd1, large_threshold: 12'd2,
			small_threshold: 12'd1, reserve_percent: 7'd0};
		settings[1] = '{slot_total: 8'd255, credit_total: 16'd65535,
			large_threshold: 12'd4095, small_threshold: 12'd4095, reserve_percent: 7'd100};
		// overlapping thresholds, reserve above full scale, totals below use
		settings[2] = '{slot_total: 8'd8, credit_total: 16'd500, large_threshold: 12'd40,
			small_threshold: 12'd200, reserve_percent: 7'd127};
		settings[3].slot_total = SLOT_W'($urandom_range(1, 32));
		settings[3].credit_total = CREDIT_W'($urandom_range(1, 2000));
		settings[3].large_threshold = SIZE_W'($urandom_range(2, 300));
		settings[3].small_threshold = SIZE_W'($urandom_range(1, 200));
		settings[3].reserve_percent = RESERVE_W'($urandom_range(0, 100));
		settings[4] = '{slot_total: 8'd2, credit_total: 16'd50, large_threshold: 12'd64,
			small_threshold: 12'd16, reserve_percent: 7'd50};
		settings[5] = '{slot_total: 8'd16, credit_total: 16'd256, large_threshold: 12'd64,
			small_threshold: 12'd16, reserve_percent: 7'd25};

		for (int p = 0; p < 6; p++) begin
			settle_block();
			load_registers(settings[p]);
			calm = (p == 5);
			for (int n = 0; n < 125; n++) begin
				it.task_number = TASK_W'($urandom_range(0, 65535));
				it.wave_number = WAVE_W'($urandom_range(0, 255));
				it.route_hint = 2'($urandom_range(0, 3));
				it.held_path = 2'($urandom_range(0, 3));
				if ($urandom_range(0, 99) < 55) begin
					it.operation = OP_REQUEST;
					if ($urandom_range(0, 99) < 60) it.route_hint = HINT_NONE;
					case ($urandom_range(0, 4))
						0: it.member_count = SIZE_W'($urandom_range(0, 4095));
						1, 2: begin
							v = ($urandom_range(0, 1) ? int'(alloc_cfg.large_threshold)
								: int'(alloc_cfg.small_threshold))
								+ int'($urandom_range(0, 6)) - 3;
							if (v < 0) v = 0;
							if (v > 4095) v = 4095;
							it.member_count = SIZE_W'(v);
						end
						3: it.member_count = SIZE_W'($urandom_range(
							32'(alloc_cfg.large_threshold), 32'(alloc_cfg.small_threshold)));
						default: it.member_count = SIZE_W'($urandom_range(0, 31));
					endcase
				end else begin
					it.operation = OP_RELEASE;
					it.member_count = SIZE_W'($urandom_range(0, 4095));
					if (held_grants.size() != 0 && $urandom_range(0, 99) < 85) begin
						idx = $urandom_range(0, held_grants.size() - 1);
						h = held_grants[idx];
						held_grants.delete(idx);
						it.held_path = h.path;
						it.member_count = h.size;
					end
				end
				push_request(it, 1'b0, '0);
			end
			req_ch.valid <= 1'b0;
		end

		while (pending_grants.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_grants.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
